FILE: design/oss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_pkg
// Shared constants, codes and types for the odd-only segmented sieve.
// ----------------------------------------------------------------------------
package oss_pkg;

    localparam int ODD_SLOTS = 65536;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (ODD_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int SLOT_W    = $clog2(ODD_SLOTS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int CNT_W     = SLOT_W + 1;

    localparam int START_W   = 63;
    localparam int LEN_W     = 18;
    localparam int PRIME_W   = 32;
    localparam int INDEX_W   = 16;
    localparam int FUNC_W    = 2;
    localparam int CFG_W     = 63;
    localparam int RUN_W     = PRIME_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STRIKE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic REG_SEGMENT_START  = 1'b0;
    localparam logic REG_SEGMENT_LENGTH = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [START_W-1:0]   dividend;
        logic [PRIME_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [PRIME_W-1:0]   rem;
    } div_rsp_t;

endpackage

FILE: design/odd_only_segmented_prime_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_only_segmented_prime_sieve
// Odd-only segmented sieve: clear, strike and query one odd-number bitmap.
// ----------------------------------------------------------------------------
// Timing: after reset the bitmap is swept to zero, during which no request is
// taken (config writes still are). A clear request takes the same sweep of the
// map RAM, one word per cycle. A strike takes a 63-step bit-serial remainder,
// then setup in the first, odd, max-square and offset states, then per struck
// slot a read and a write-back of the word through the single RAM port pair.
// A query takes one RAM read, then loads the result register once the output
// is free.
// Strike with base prime 0, and func 3, finish with no result.
module odd_only_segmented_prime_sieve
    import oss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // base_prime[31:0], slot_index[47:32]
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // is_prime[0], number_value[63:1]
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_CLR   = 12'b000000000010,
        ST_DIV   = 12'b000000000100,
        ST_FIRST = 12'b000000001000,
        ST_ODD   = 12'b000000010000,
        ST_MAXSQ = 12'b000000100000,
        ST_JOFF  = 12'b000001000000,
        ST_ROFF  = 12'b000010000000,
        ST_MRD   = 12'b000100000000,
        ST_MWR   = 12'b001000000000,
        ST_QRD   = 12'b010000000000,
        ST_QOUT  = 12'b100000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [START_W-1:0]   start_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic                 mark1_reg, mark1_next;
    logic [PRIME_W-1:0]   p_reg, p_next;
    logic [INDEX_W-1:0]   slot_reg, slot_next;
    logic [63:0]          first_reg, first_next;
    logic [63:0]          sq_reg, sq_next;
    logic [START_W-1:0]   j_reg, j_next;
    logic [RUN_W-1:0]     r_reg, r_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_data_reg, out_data_next;

    logic [CNT_W-1:0]     slots;
    logic [LEN_W-2:0]     half_len;
    logic [START_W-2:0]   base;
    logic [START_W-1:0]   roff;
    logic [PRIME_W-1:0]   gap;
    logic                 in_fire;
    logic [PRIME_W-1:0]   in_prime;
    logic [INDEX_W-1:0]   in_slot;
    logic                 in_seg;
    logic [START_W-2:0]   qsum;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

    assign half_len = len_reg[LEN_W-1:1];
    assign slots    = (half_len > (LEN_W-1)'(ODD_SLOTS)) ? CNT_W'(ODD_SLOTS)
                                                         : CNT_W'(half_len);
    assign base     = start_reg[START_W-1:1];
    assign in_prime = s_tdata[PRIME_W-1:0];
    assign in_slot  = s_tdata[PRIME_W +: INDEX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign gap      = p_reg - div_rsp.rem;
    assign roff     = j_reg - {1'b0, base};
    assign in_seg   = {1'b0, slot_reg} < CNT_W'(slots);
    assign qsum     = base + (START_W-1)'(slot_reg);

    oss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    oss_map #(
        .AW (ADDR_W),
        .DW (WORD_BITS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        mark1_next     = mark1_reg;
        p_next         = p_reg;
        slot_next      = slot_reg;
        first_next     = first_reg;
        sq_next        = sq_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = start_reg;
        div_req.divisor  = in_prime;
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_reg[SLOT_W-1:BIT_W];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    p_next    = in_prime;
                    slot_next = in_slot;
                    case (s_tuser)
                        FUNC_CLEAR:
                        begin
                            clr_next   = '0;
                            mark1_next = (start_reg[START_W-1:1] == '0);
                            state_next = ST_CLR;
                        end
                        FUNC_STRIKE:
                        begin
                            if (in_prime != '0)
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            state_next = ST_QRD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLR:
            begin
                mem_we = 1'b1;
                if (clr_reg == '0 && mark1_reg)
                    mem_wdata = WORD_BITS'(1);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {ADDR_W{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem != '0)
                        first_next = {1'b0, start_reg} + {32'b0, gap};
                    else
                        first_next = {1'b0, start_reg};
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                sq_next = p_reg * p_reg;
                if (!first_reg[0])
                    first_next = first_reg + {32'b0, p_reg};
                state_next = ST_ODD;
            end
            ST_ODD:
            begin
                if (sq_reg > first_reg)
                    first_next = sq_reg;
                state_next = ST_MAXSQ;
            end
            ST_MAXSQ:
            begin
                j_next     = START_W'((first_reg - 64'd1) >> 1);
                state_next = ST_JOFF;
            end
            ST_JOFF:
            begin
                r_next = RUN_W'(roff);
                if (j_reg < {1'b0, base} ||
                    roff >= START_W'(slots))
                    state_next = ST_IDLE;
                else
                    state_next = ST_MRD;
            end
            ST_ROFF:
            begin
                state_next = ST_MRD;
            end
            ST_MRD:
            begin
                mem_re     = 1'b1;
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = r_reg[SLOT_W-1:BIT_W];
                mem_wdata = mem_rdata | (WORD_BITS'(1) << r_reg[BIT_W-1:0]);
                r_next    = r_reg + RUN_W'(p_reg);
                if (r_next < RUN_W'(slots))
                    state_next = ST_MRD;
                else
                    state_next = ST_IDLE;
            end
            ST_QRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = slot_reg[SLOT_W-1:BIT_W];
                state_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {qsum, 1'b1,
                                      in_seg && !mem_rdata[slot_reg[BIT_W-1:0]]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            mark1_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            len_reg       <= LEN_W'(131072);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            mark1_reg     <= mark1_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_addr == REG_SEGMENT_START)
                start_reg <= cfg_wdata[START_W-1:0];
            if (cfg_we && cfg_addr == REG_SEGMENT_LENGTH)
                len_reg <= cfg_wdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        slot_reg     <= slot_next;
        first_reg    <= first_next;
        sq_reg       <= sq_next;
        j_reg        <= j_next;
        r_reg        <= r_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLR || state_reg == ST_MWR))
        else $error("map write outside clear or strike");
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRD) |-> (r_reg < RUN_W'(slots)))
        else $error("strike slot beyond segment");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("remainder ready outside divide wait");
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_QOUT))
        else $error("result without query");
`endif

endmodule

FILE: design/oss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_div
// Restoring divider, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module oss_div
    import oss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(START_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [START_W-1:0]   quo_reg, quo_next;
    logic [PRIME_W-1:0]   den_reg, den_next;
    logic [PRIME_W-1:0]   rem_reg, rem_next;
    logic [PRIME_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, quo_reg[START_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(START_W);
            quo_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
                rem_next = PRIME_W'(trial - {1'b0, den_reg});
            else
                rem_next = PRIME_W'(trial);
            quo_next = {quo_reg[START_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: design/oss_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_map
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oss_map #(
    parameter int AW = 10,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule
